[rtl/running_histogram_median_filter_core_assert.svh]
// assertion macros for the median filter port checker
`ifndef RUNNING_HISTOGRAM_MEDIAN_FILTER_CORE_ASSERT_SVH
`define RUNNING_HISTOGRAM_MEDIAN_FILTER_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define RHM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhm check failed");

// next-cycle implication, masked during reset
`define RHM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhm check failed");

// next-cycle implication that also holds across reset
`define RHM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rhm check failed");

`endif

[rtl/rhm_pkg.sv]
// shared types and constants of the running histogram median filter
package rhm_pkg;

  localparam int LEVELS       = 256;
  localparam int LVL_W        = 8;
  localparam int CNT_W        = 6;
  localparam int PIX_W        = 8;
  localparam int PIX_INPUTS   = 7;
  localparam int ROW_W        = 3;
  localparam int HALF_W       = 2;
  localparam int HALF_CAP     = 3;
  localparam int MAX_HALF_DEF = 3;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd1;

  typedef struct packed {
    logic                                row_start;
    logic [PIX_INPUTS-1:0][PIX_W-1:0]    pix;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RM_CS,
    BK_RM_HR,
    BK_RM_HW,
    BK_AD_HR,
    BK_AD_HW,
    BK_WK_RD,
    BK_WK_EV,
    BK_UP_RD,
    BK_UP_EV,
    BK_OUT
  } bk_state_t;

endpackage

[rtl/rhm_ram.sv]
// generic single write port ram with registered read
module rhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rhm_front.sv]
// input stage: accepts columns into a two entry queue
module rhm_front import rhm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);

  item_t      mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

endmodule

[rtl/rhm_back.sv]
// histogram update, median walk, config registers and result register
module rhm_back import rhm_pkg::*; #(
  parameter int MAX_HALF = MAX_HALF_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  item_t                q_item,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [HALF_W-1:0]    cfg_val,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LVL_W-1:0]     out_median_level
);

  localparam int CAP      = (MAX_HALF > HALF_CAP) ? HALF_CAP : MAX_HALF;
  localparam int SPAN     = 2 * CAP + 1;
  localparam int CS_DEPTH = SPAN * SPAN;
  localparam int CS_AW    = $clog2(CS_DEPTH);
  localparam int SEEN_W   = $clog2(SPAN + 1);
  localparam logic [HALF_W-1:0] CAP_V = HALF_W'(CAP);

  bk_state_t            state_r, state_nxt;
  item_t                item_r, item_nxt;
  logic [SEEN_W-1:0]    r_r, r_nxt;
  logic [SEEN_W-1:0]    slot_r, slot_nxt;
  logic [SEEN_W-1:0]    head_r, head_nxt;
  logic [SEEN_W-1:0]    seen_r, seen_nxt;
  logic                 rmv_r, rmv_nxt;
  logic [LVL_W-1:0]     p_r, p_nxt;
  logic [LVL_W-1:0]     med_r, med_nxt;
  logic [CNT_W-1:0]     cab_r, cab_nxt;
  logic [HALF_W-1:0]    hw_r, hw_nxt;
  logic [HALF_W-1:0]    hh_r, hh_nxt;
  logic [LEVELS-1:0]    vld_r, vld_nxt;
  logic                 vq_r, vq_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]     out_med_r, out_med_nxt;

  logic                 cs_we, cs_re;
  logic [CS_AW-1:0]     cs_waddr, cs_raddr;
  logic [PIX_W-1:0]     cs_wdata, cs_rdata;
  logic                 h_we, h_re;
  logic [LVL_W-1:0]     h_waddr, h_raddr;
  logic [CNT_W-1:0]     h_wdata, h_rdata;

  logic [SEEN_W-1:0]    w_v, h_v;
  logic [CNT_W:0]       prod1;
  logic [CNT_W-1:0]     target;
  logic [CNT_W-1:0]     cnt;
  logic [CS_AW-1:0]     slot_addr;
  logic [SEEN_W-1:0]    seen_eff, head_eff;
  logic [PIX_W-1:0]     pix_sel;
  logic [HALF_W-1:0]    cfg_sat;

  assign w_v       = SEEN_W'({hw_r, 1'b1});
  assign h_v       = SEEN_W'({hh_r, 1'b1});
  assign prod1     = (CNT_W + 1)'(CNT_W'(w_v) * CNT_W'(h_v)) + 1'b1;
  assign target    = prod1[CNT_W:1];
  assign cnt       = vq_r ? h_rdata : '0;
  assign slot_addr = CS_AW'(slot_r) * CS_AW'(SPAN) + CS_AW'(r_r);
  assign pix_sel   = item_r.pix[ROW_W'(r_r)];
  assign cfg_sat   = (cfg_val > CAP_V) ? CAP_V : cfg_val;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    r_nxt         = r_r;
    slot_nxt      = slot_r;
    head_nxt      = head_r;
    seen_nxt      = seen_r;
    rmv_nxt       = rmv_r;
    p_nxt         = p_r;
    med_nxt       = med_r;
    cab_nxt       = cab_r;
    hw_nxt        = hw_r;
    hh_nxt        = hh_r;
    vld_nxt       = vld_r;
    vq_nxt        = vq_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_med_nxt   = out_med_r;
    q_pop         = 1'b0;
    cs_we         = 1'b0;
    cs_waddr      = slot_addr;
    cs_wdata      = pix_sel;
    cs_re         = 1'b0;
    cs_raddr      = slot_addr;
    h_we          = 1'b0;
    h_waddr       = p_r;
    h_wdata       = cnt;
    h_re          = 1'b0;
    h_raddr       = med_r;
    seen_eff      = seen_r;
    head_eff      = head_r;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          r_nxt    = '0;
          if (q_item.row_start) begin
            seen_eff = '0;
            head_eff = '0;
            vld_nxt  = '0;
            med_nxt  = '0;
            cab_nxt  = '0;
            head_nxt = '0;
          end
          if (seen_eff >= w_v) begin
            slot_nxt  = head_eff;
            rmv_nxt   = 1'b1;
            seen_nxt  = seen_eff;
            state_nxt = BK_RM_CS;
          end else begin
            slot_nxt  = seen_eff;
            rmv_nxt   = 1'b0;
            seen_nxt  = seen_eff + 1'b1;
            state_nxt = BK_AD_HR;
          end
        end
      end
      BK_RM_CS: begin
        cs_re     = 1'b1;
        state_nxt = BK_RM_HR;
      end
      BK_RM_HR: begin
        p_nxt     = cs_rdata;
        h_re      = 1'b1;
        h_raddr   = cs_rdata;
        vq_nxt    = vld_r[cs_rdata];
        state_nxt = BK_RM_HW;
      end
      BK_RM_HW: begin
        h_we           = 1'b1;
        h_wdata        = cnt - 1'b1;
        vld_nxt[p_r]   = 1'b1;
        if (p_r <= med_r) begin
          cab_nxt = cab_r - 1'b1;
        end
        if (r_r + 1'b1 == h_v) begin
          r_nxt     = '0;
          state_nxt = BK_AD_HR;
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = BK_RM_CS;
        end
      end
      BK_AD_HR: begin
        cs_we     = 1'b1;
        p_nxt     = pix_sel;
        h_re      = 1'b1;
        h_raddr   = pix_sel;
        vq_nxt    = vld_r[pix_sel];
        state_nxt = BK_AD_HW;
      end
      BK_AD_HW: begin
        h_we         = 1'b1;
        h_wdata      = cnt + 1'b1;
        vld_nxt[p_r] = 1'b1;
        if (p_r <= med_r) begin
          cab_nxt = cab_r + 1'b1;
        end
        if (r_r + 1'b1 == h_v) begin
          r_nxt = '0;
          if (rmv_r) begin
            head_nxt = (head_r == w_v - 1'b1) ? '0 : head_r + 1'b1;
          end
          state_nxt = (rmv_r || seen_r == w_v) ? BK_WK_RD : BK_IDLE;
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = BK_AD_HR;
        end
      end
      BK_WK_RD: begin
        h_re      = 1'b1;
        vq_nxt    = vld_r[med_r];
        state_nxt = BK_WK_EV;
      end
      BK_WK_EV: begin
        // cab holds the count of window pixels at or below med
        if (cab_r < target) begin
          med_nxt   = med_r + 1'b1;
          state_nxt = BK_UP_RD;
        end else if ({1'b0, cab_r} >= {1'b0, cnt} + {1'b0, target}) begin
          cab_nxt   = cab_r - cnt;
          med_nxt   = med_r - 1'b1;
          state_nxt = BK_WK_RD;
        end else begin
          state_nxt = BK_OUT;
        end
      end
      BK_UP_RD: begin
        h_re      = 1'b1;
        vq_nxt    = vld_r[med_r];
        state_nxt = BK_UP_EV;
      end
      BK_UP_EV: begin
        cab_nxt   = cab_r + cnt;
        state_nxt = BK_WK_EV;
      end
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_med_nxt   = med_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // a register write clears the window like a row start
    if (cfg_wr && (cfg_idx inside {CFG_HALF_WIDTH, CFG_HALF_HEIGHT})) begin
      if (cfg_idx == CFG_HALF_WIDTH) begin
        hw_nxt = cfg_sat;
      end else begin
        hh_nxt = cfg_sat;
      end
      vld_nxt  = '0;
      seen_nxt = '0;
      head_nxt = '0;
      med_nxt  = '0;
      cab_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      seen_r      <= '0;
      head_r      <= '0;
      med_r       <= '0;
      cab_r       <= '0;
      hw_r        <= HALF_W'(1);
      hh_r        <= HALF_W'(1);
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      head_r      <= head_nxt;
      med_r       <= med_nxt;
      cab_r       <= cab_nxt;
      hw_r        <= hw_nxt;
      hh_r        <= hh_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    r_r       <= r_nxt;
    slot_r    <= slot_nxt;
    rmv_r     <= rmv_nxt;
    p_r       <= p_nxt;
    vq_r      <= vq_nxt;
    out_med_r <= out_med_nxt;
  end

  rhm_ram #(.WIDTH(PIX_W), .DEPTH(CS_DEPTH)) u_col_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (cs_wdata),
    .re    (cs_re),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  rhm_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_median_level = out_med_r;

endmodule

[rtl/running_histogram_median_filter_core.sv]
// Running histogram median filter: one image column per transaction, the
// window median per transaction once the window is full. Columns are handled
// one at a time; each first removes the oldest column (once the window is full)
// row by row, reading its pixel from the column memory and then reading and
// writing the histogram, then adds the new column row by row, then walks the
// median over the histogram memory level by level down or up, then emits it.
// The histogram memory, used for one access per cycle, paces this work.
// A two-transaction input queue lets columns arrive while one is in work, and
// the result register lets the next column start while a median waits.
// Histogram clearing on row start or register write is instant (valid bits).
module running_histogram_median_filter_core import rhm_pkg::*; #(
  parameter int MAX_HALF = MAX_HALF_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_row_start,
  input  logic [PIX_W-1:0]     in_pixel_row0,
  input  logic [PIX_W-1:0]     in_pixel_row1,
  input  logic [PIX_W-1:0]     in_pixel_row2,
  input  logic [PIX_W-1:0]     in_pixel_row3,
  input  logic [PIX_W-1:0]     in_pixel_row4,
  input  logic [PIX_W-1:0]     in_pixel_row5,
  input  logic [PIX_W-1:0]     in_pixel_row6,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LVL_W-1:0]     out_median_level,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data
);

  item_t in_item, q_item;
  logic  q_valid, q_pop;

  assign in_item.row_start = in_row_start;
  assign in_item.pix       = {in_pixel_row6, in_pixel_row5, in_pixel_row4,
                              in_pixel_row3, in_pixel_row2, in_pixel_row1,
                              in_pixel_row0};
  assign cfg_ready = 1'b1;

  rhm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  rhm_back #(.MAX_HALF(MAX_HALF)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_idx          (cfg_index),
    .cfg_val          (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_level (out_median_level)
  );

endmodule

[rtl/rhm_checker.sv]
// port-level checker for the median filter core and its bind
`include "running_histogram_median_filter_core_assert.svh"

module rhm_checker import rhm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [LVL_W-1:0]     out_median_level,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  `RHM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `RHM_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_median_level))
  `RHM_ASSERT_RST(a_reset_clears, !rst_n, !out_valid)
  `RHM_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind running_histogram_median_filter_core rhm_checker u_rhm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_median_level (out_median_level),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready)
);

[verif/median_checker.sv]
// median filter checker: tracks column transactions, predicts medians, compares results
module median_checker import rhm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_row_start,
  input  logic [PIX_W-1:0]     in_pixel_row0,
  input  logic [PIX_W-1:0]     in_pixel_row1,
  input  logic [PIX_W-1:0]     in_pixel_row2,
  input  logic [PIX_W-1:0]     in_pixel_row3,
  input  logic [PIX_W-1:0]     in_pixel_row4,
  input  logic [PIX_W-1:0]     in_pixel_row5,
  input  logic [PIX_W-1:0]     in_pixel_row6,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [LVL_W-1:0]     out_median_level,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data,
  output int                   medians_pending,
  output int                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CNT_W-1:0] hist [LEVELS];
  logic [PIX_W-1:0] win_cols [PIX_INPUTS][PIX_INPUTS];
  logic [ROW_W-1:0] cols_in_win;
  logic [HALF_W-1:0] half_w, half_h;
  logic [LVL_W-1:0] median_queue [$];

  function automatic void clear_window();
    for (int i = 0; i < LEVELS; i++) hist[i] = '0;
    cols_in_win = '0;
  endfunction

  // returns 1 when the window is full and a median comes out
  function automatic bit predict_median(input logic rs, input logic [PIX_W-1:0] px [PIX_INPUTS],
                                        output logic [LVL_W-1:0] med);
    int w, h, slot, target, cum;
    w = 2 * half_w + 1;
    h = 2 * half_h + 1;
    med = '1;
    if (rs) clear_window();
    if (cols_in_win >= w) begin
      for (int r = 0; r < h; r++) hist[win_cols[0][r]] = hist[win_cols[0][r]] - 1'b1;
      for (int c = 1; c < w; c++)
        for (int r = 0; r < h; r++) win_cols[c-1][r] = win_cols[c][r];
      slot = w - 1;
    end else begin
      slot = cols_in_win;
      cols_in_win = cols_in_win + 1'b1;
    end
    for (int r = 0; r < h; r++) begin
      win_cols[slot][r] = px[r];
      hist[px[r]] = hist[px[r]] + 1'b1;
    end
    if (cols_in_win < w) return 0;
    target = (w * h + 1) / 2;
    cum = 0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      cum += hist[lv];
      if (cum >= target) begin
        med = lv[LVL_W-1:0];
        break;
      end
    end
    return 1;
  endfunction

  assign medians_pending = median_queue.size();

  always @(posedge clk) begin
    logic [PIX_W-1:0] px [PIX_INPUTS];
    logic [LVL_W-1:0] med, exp_med;
    if (!rst_n) begin
      half_w = 2'd1;
      half_h = 2'd1;
      clear_window();
      median_queue.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (median_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected median transaction: got %0d", out_median_level);
          fail_count <= fail_count + 1;
        end else begin
          exp_med = median_queue.pop_front();
          if (exp_med !== out_median_level) begin
            if (fail_count < 10)
              $display("median mismatch: expected %0d got %0d", exp_med, out_median_level);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HALF_WIDTH) begin
          half_w = cfg_data;
          clear_window();
        end else if (cfg_index == CFG_HALF_HEIGHT) begin
          half_h = cfg_data;
          clear_window();
        end
      end
      if (in_valid && !in_stall) begin
        px[0] = in_pixel_row0; px[1] = in_pixel_row1; px[2] = in_pixel_row2;
        px[3] = in_pixel_row3; px[4] = in_pixel_row4; px[5] = in_pixel_row5;
        px[6] = in_pixel_row6;
        if (predict_median(in_row_start, px, med)) median_queue.push_back(med);
      end
    end
  end
endmodule

[verif/tb_top.sv]
// top of the median filter testbench: clock, reset, column and register stimulus, verdict
module tb_top import rhm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 1200;   // one column with a full median walk, with margin
  localparam int CYCLE_LIMIT   = 10000000;

  logic clk, rst_n;
  logic in_valid, in_stall, in_row_start;
  logic [PIX_W-1:0] in_px [PIX_INPUTS];
  logic out_valid, out_stall;
  logic [LVL_W-1:0] out_median_level;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HALF_W-1:0] cfg_data;
  int medians_pending, fail_count;
  int send_idle_pct, recv_idle_pct;
  bit long_hold_go;
  int cycle_cnt;

  running_histogram_median_filter_core i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_row_start,
    .in_pixel_row0(in_px[0]), .in_pixel_row1(in_px[1]), .in_pixel_row2(in_px[2]),
    .in_pixel_row3(in_px[3]), .in_pixel_row4(in_px[4]), .in_pixel_row5(in_px[5]),
    .in_pixel_row6(in_px[6]),
    .out_valid, .out_stall, .out_median_level,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  median_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_row_start,
    .in_pixel_row0(in_px[0]), .in_pixel_row1(in_px[1]), .in_pixel_row2(in_px[2]),
    .in_pixel_row3(in_px[3]), .in_pixel_row4(in_px[4]), .in_pixel_row5(in_px[5]),
    .in_pixel_row6(in_px[6]),
    .out_valid, .out_stall, .out_median_level,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .medians_pending, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side stall, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_go) begin
        out_stall <= 1'b1;
        repeat (800) @(negedge clk);
        long_hold_go = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_column(input logic rs, input logic [PIX_W-1:0] px [PIX_INPUTS]);
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) in_valid <= 1'b0;
      else break;
    end
    in_row_start <= rs;
    for (int r = 0; r < PIX_INPUTS; r++) in_px[r] <= px[r];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // register writes happen only with the filter drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (medians_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_row(input int len, input bit clustered);
    logic [PIX_W-1:0] px [PIX_INPUTS];
    int base;
    base = $urandom_range(255);
    for (int c = 0; c < len; c++) begin
      for (int r = 0; r < PIX_INPUTS; r++)
        px[r] = clustered ? PIX_W'(base + $urandom_range(15)) : PIX_W'($urandom);
      // stray row starts now and then break a row early
      send_column(c == 0 || $urandom_range(49) == 0, px);
    end
  endtask

  initial begin
    logic [PIX_W-1:0] px [PIX_INPUTS];
    logic [HALF_W-1:0] hw_set [7] = '{2'd1, 2'd0, 2'd3, 2'd0, 2'd3, 2'd2, 2'd1};
    logic [HALF_W-1:0] hh_set [7] = '{2'd1, 2'd0, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2};
    int sent, len, w;
    bit hold_done;
    cycle_cnt = 0;
    hold_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_row_start = 1'b0;
    for (int r = 0; r < PIX_INPUTS; r++) in_px[r] = '0;
    cfg_valid = 1'b0; cfg_index = CFG_HALF_WIDTH; cfg_data = '0;
    send_idle_pct = 26; recv_idle_pct = 62;
    long_hold_go = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: all black, all white, extremes mixed, row start inside a full window
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < PIX_INPUTS; r++) px[r] = '0;
      send_column(c == 0, px);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < PIX_INPUTS; r++) px[r] = '1;
      send_column(c == 0, px);
    end
    for (int c = 0; c < 6; c++) begin
      for (int r = 0; r < PIX_INPUTS; r++) px[r] = ((r + c) % 2) ? 8'hff : 8'h00;
      send_column(c == 0 || c == 4, px);
    end
    for (int c = 0; c < 5; c++) begin
      for (int r = 0; r < PIX_INPUTS; r++) px[r] = (c == 4) ? 8'h80 : 8'h7f;
      send_column(1'b0, px);
    end
    // indexes past the register list are ignored
    write_reg(2'd2, 2'd3);
    write_reg(2'd3, 2'd0);

    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        send_idle_pct = 62; recv_idle_pct = 26;
      end else if (p == 5) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (p > 0) begin
        write_reg(CFG_HALF_WIDTH, hw_set[p]);
        write_reg(CFG_HALF_HEIGHT, hh_set[p]);
      end
      w = 2 * hw_set[p] + 1;
      sent = 0;
      while (sent < 220) begin
        if (p == 1 && sent >= 40 && !hold_done) begin
          long_hold_go = 1'b1;
          hold_done = 1'b1;
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(1, w) : $urandom_range(w, w + 12);
        send_row(len, $urandom_range(2) == 0);
        sent += len;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (medians_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && medians_pending == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/rhm_pkg.sv
rtl/rhm_ram.sv
rtl/rhm_front.sv
rtl/rhm_back.sv
rtl/running_histogram_median_filter_core.sv
rtl/rhm_checker.sv
verif/median_checker.sv
verif/tb_top.sv
